// ----- rtl/spc_pkg.sv -----
`default_nettype none

package spc_pkg;

  localparam int DEF_SAMPLE_FRAC_BITS = 18;

  // Fixed field and register widths
  localparam int SAMPLE_W   = 23;
  localparam int MODE_W     = 2;
  localparam int THR_W      = 19;
  localparam int GAIN_W     = 23;
  localparam int WET_W      = 17;
  localparam int COEF_W     = 25;
  localparam int SEG_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  // Arithmetic widths
  localparam int GR_W      = 25;
  localparam int DIV_CNT_W = 5;
  localparam int MUL_W     = 32;
  localparam int PROD_W    = 64;

  localparam logic [COEF_W-1:0] ONE_Q24 = 25'd16777216;
  localparam logic [WET_W-1:0]  WET_ONE = 17'd65536;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAKEUP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WET       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_REL  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_REL  = 3'd6;

  // Mode codes; the fourth code acts as the limiter
  localparam logic [MODE_W-1:0] MODE_COMP   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BYPASS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LIMIT  = 2'd2;

  // Register reset values
  localparam logic [MODE_W-1:0] RST_MODE      = MODE_COMP;
  localparam logic [THR_W-1:0]  RST_THRESHOLD = 19'd131072;
  localparam logic [GAIN_W-1:0] RST_MAKEUP    = 23'd207243;
  localparam logic [WET_W-1:0]  RST_WET       = 17'd65536;
  localparam logic [COEF_W-1:0] RST_ATTACK    = 25'd16742282;
  localparam logic [COEF_W-1:0] RST_FAST_REL  = 25'd16771391;
  localparam logic [COEF_W-1:0] RST_SLOW_REL  = 25'd16776983;

  // Gain reduction boundaries of the meter segments, 0 to -24 dB
  localparam int METER_N = 9;
  localparam logic [GR_W-1:0] METER_BOUNDS [METER_N] = '{
    25'd14389748, 25'd10585707, 25'd7787294, 25'd5728663, 25'd4214245,
    25'd3100178, 25'd2280621, 25'd1677722, 25'd1234202
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COEF,
    ST_ENV_A,
    ST_ENV_B,
    ST_ENV_UPD,
    ST_THR,
    ST_DIV,
    ST_MAKEUP,
    ST_WG,
    ST_WET,
    ST_MIX,
    ST_APPLY_L,
    ST_APPLY_R,
    ST_SAT_R,
    ST_DONE
  } state_t;

  function automatic logic [SEG_W-1:0] meter_count(input logic [GR_W-1:0] gr);
    logic [SEG_W-1:0] n;
    n = '0;
    for (int k = 0; k < METER_N; k++) begin
      if (gr <= METER_BOUNDS[k]) n = n + SEG_W'(1);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/spc_div.sv -----
`default_nettype none

module spc_div #(
  parameter int SAMPLE_FRAC_BITS = spc_pkg::DEF_SAMPLE_FRAC_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [SAMPLE_FRAC_BITS+8:0]       den,
  output logic                                   done,
  output logic [spc_pkg::GR_W-1:0]               quot
);
  import spc_pkg::*;

  localparam int F  = SAMPLE_FRAC_BITS;
  localparam int DW = F + 9;
  localparam int NW = F + 25;
  localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(GR_W - 1);

  logic [NW-1:0]        num;
  logic [DW-1:0]        den_r;
  logic [DW-1:0]        rem_r;
  logic [DW-1:0]        rem_nxt;
  logic [GR_W-1:0]      q_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DW:0]          rem_sh;
  logic [DW:0]          rem_sub;
  logic                 ge;

  // Round half up: divide 2^(F+24) + den/2 by den
  assign num = (NW'(1) << (F + 24)) + NW'(den >> 1);

  // The quotient fits in GR_W bits, so the top of the numerator is already below den
  assign rem_sh  = {rem_r, q_r[GR_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_nxt = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= DW'(num[NW-1:GR_W]);
      q_r   <= num[GR_W-1:0];
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[GR_W-2:0], ge};
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == LAST)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (q_r <= ONE_Q24))
    else $error("gain reduction above unity");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held longer than one cycle");

endmodule

`default_nettype wire

// ----- rtl/stereo_peak_compressor.sv -----
`default_nettype none

// Stereo feedforward compressor: one request is a stereo sample pair, one result
// is the processed pair with a clip flag and a 0..9 segment reduction meter.
// Items are processed one at a time through a single shared 32x32 multiplier
// and a 25-step restoring divider under a small sequencer. From acceptance to
// the output register a bypass item goes straight to the final state, while
// other items pass the coefficient, envelope, threshold, gain, mix and apply
// states, with the divider wait added above threshold. The next request is
// accepted as soon as the previous result has moved to the output register.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata.

module stereo_peak_compressor #(
  parameter int SAMPLE_FRAC_BITS = spc_pkg::DEF_SAMPLE_FRAC_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [spc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [spc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [spc_pkg::SAMPLE_W-1:0]   in_left_sample,
  input  wire logic signed [spc_pkg::SAMPLE_W-1:0]   in_right_sample,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [spc_pkg::SAMPLE_W-1:0]        out_left_out,
  output logic signed [spc_pkg::SAMPLE_W-1:0]        out_right_out,
  output logic                                       out_clip_flag,
  output logic [spc_pkg::SEG_W-1:0]                  out_meter_segments
);
  import spc_pkg::*;

  localparam int F  = SAMPLE_FRAC_BITS;
  localparam int EW = F + 4;
  localparam int SW = (F + 6 > SAMPLE_W + 1) ? F + 6 : SAMPLE_W + 1;
  localparam int DW = F + 9;
  localparam int CW = (EW > THR_W) ? EW : THR_W;
  localparam int MW = PROD_W - 24;

  localparam logic [EW-1:0]        VMAX_E  = EW'(64'd10 << F);
  localparam logic signed [SW-1:0] VMAX_S  = SW'(64'd10 << F);
  localparam logic [EW-1:0]        V_TENTH = EW'(((64'd1 << F) + 64'd5) / 64'd10);
  localparam logic [EW-1:0]        V_CLIP  = EW'(((64'd99 << F) + 64'd5) / 64'd10);
  localparam logic [PROD_W-1:0]    HALF16  = PROD_W'(64'd1 << 15);
  localparam logic [PROD_W-1:0]    HALF24  = PROD_W'(64'd1 << 23);

  // Configuration registers
  logic [MODE_W-1:0] mode_r;
  logic [THR_W-1:0]  thr_r;
  logic [GAIN_W-1:0] makeup_r;
  logic [WET_W-1:0]  wet_r;
  logic [COEF_W-1:0] attack_r;
  logic [COEF_W-1:0] fast_rel_r;
  logic [COEF_W-1:0] slow_rel_r;

  state_t state_r;
  state_t state_nxt;

  logic signed [SW-1:0] l_r;
  logic signed [SW-1:0] r_r;
  logic                 byp_r;
  logic [EW-1:0]        rect_r;
  logic [EW-1:0]        env_r;
  logic [COEF_W-1:0]    c_r;
  logic [PROD_W-1:0]    prod_r;
  logic [PROD_W-1:0]    acc_r;
  logic [GR_W-1:0]      gr_r;
  logic [MUL_W-1:0]     wg_r;
  logic [MUL_W-1:0]     t_r;
  logic [EW-1:0]        lmag_r;
  logic [EW-1:0]        rmag_r;
  logic                 out_valid_r;
  logic signed [SAMPLE_W-1:0] out_left_r;
  logic signed [SAMPLE_W-1:0] out_right_r;
  logic                 out_clip_r;
  logic [SEG_W-1:0]     out_seg_r;

  logic                 in_accept;
  logic                 out_load;
  logic signed [SW-1:0] in_l_x;
  logic signed [SW-1:0] in_r_x;
  logic signed [SW-1:0] in_l_c;
  logic signed [SW-1:0] in_r_c;
  logic signed [SW-1:0] in_sum;
  logic [SW-1:0]        in_sum_abs;
  logic [COEF_W-1:0]    c_raw;
  logic [COEF_W-1:0]    c_sel;
  logic [COEF_W-1:0]    one_minus_c;
  logic [PROD_W-1:0]    env_sum;
  logic                 over;
  logic [EW-1:0]        diff;
  logic [DW-1:0]        den_calc;
  logic [WET_W-1:0]     wet_sat;
  logic [PROD_W-1:0]    wg_sum;
  logic [PROD_W-1:0]    mix_sum;
  logic [PROD_W-1:0]    rnd;
  logic [MW-1:0]        m_full;
  logic [EW-1:0]        m_sat;
  logic [SW-1:0]        l_abs;
  logic [SW-1:0]        r_abs;
  logic signed [SW-1:0] lo_s;
  logic signed [SW-1:0] ro_s;
  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic                 div_start;
  logic                 div_done;
  logic [GR_W-1:0]      div_quot;

  // Configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= RST_MODE;
      thr_r      <= RST_THRESHOLD;
      makeup_r   <= RST_MAKEUP;
      wet_r      <= RST_WET;
      attack_r   <= RST_ATTACK;
      fast_rel_r <= RST_FAST_REL;
      slow_rel_r <= RST_SLOW_REL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:      mode_r     <= cfg_wdata[MODE_W-1:0];
        REG_THRESHOLD: thr_r      <= cfg_wdata[THR_W-1:0];
        REG_MAKEUP:    makeup_r   <= cfg_wdata[GAIN_W-1:0];
        REG_WET:       wet_r      <= cfg_wdata[WET_W-1:0];
        REG_ATTACK:    attack_r   <= cfg_wdata[COEF_W-1:0];
        REG_FAST_REL:  fast_rel_r <= cfg_wdata[COEF_W-1:0];
        REG_SLOW_REL:  slow_rel_r <= cfg_wdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Input clamp and rectified mono mix
  assign in_l_x     = SW'(in_left_sample);
  assign in_r_x     = SW'(in_right_sample);
  assign in_l_c     = (in_l_x > VMAX_S) ? VMAX_S : ((in_l_x < -VMAX_S) ? -VMAX_S : in_l_x);
  assign in_r_c     = (in_r_x > VMAX_S) ? VMAX_S : ((in_r_x < -VMAX_S) ? -VMAX_S : in_r_x);
  assign in_sum     = in_l_c + in_r_c;
  assign in_sum_abs = (in_sum < 0) ? SW'(-in_sum) : SW'(in_sum);

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Coefficient choice: attack on a rise, release by envelope level
  always_comb begin
    priority if (rect_r > env_r) begin
      c_raw = attack_r;
    end else if (env_r > V_TENTH) begin
      c_raw = fast_rel_r;
    end else begin
      c_raw = slow_rel_r;
    end
    c_sel = (c_raw > ONE_Q24) ? ONE_Q24 : c_raw;
  end

  assign one_minus_c = ONE_Q24 - c_r;
  assign env_sum     = acc_r + prod_r + HALF24;

  assign over     = CW'(env_r) > CW'(thr_r);
  assign diff     = env_r - EW'(thr_r);
  assign den_calc = DW'(64'd1 << F) +
                    ((mode_r == MODE_COMP) ? (DW'(diff) << 1)
                                           : ((DW'(diff) << 3) + DW'(diff)));

  assign wet_sat = (wet_r > WET_ONE) ? WET_ONE : wet_r;
  assign wg_sum  = prod_r + HALF16;
  assign mix_sum = (PROD_W'(WET_ONE - wet_sat) << 24) + prod_r + HALF16;

  // Round and saturate a scaled magnitude
  assign rnd    = prod_r + HALF24;
  assign m_full = rnd[PROD_W-1:24];
  assign m_sat  = (m_full > MW'(VMAX_E)) ? VMAX_E : m_full[EW-1:0];

  assign l_abs = (l_r < 0) ? SW'(-l_r) : SW'(l_r);
  assign r_abs = (r_r < 0) ? SW'(-r_r) : SW'(r_r);
  assign lo_s  = (l_r < 0) ? -$signed(SW'(lmag_r)) : $signed(SW'(lmag_r));
  assign ro_s  = (r_r < 0) ? -$signed(SW'(rmag_r)) : $signed(SW'(rmag_r));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = (mode_r == MODE_BYPASS) ? ST_DONE : ST_COEF;
      end
      ST_COEF:    state_nxt = ST_ENV_A;
      ST_ENV_A:   state_nxt = ST_ENV_B;
      ST_ENV_B:   state_nxt = ST_ENV_UPD;
      ST_ENV_UPD: state_nxt = ST_THR;
      ST_THR:     state_nxt = over ? ST_DIV : ST_MAKEUP;
      ST_DIV: begin
        if (div_done) state_nxt = ST_MAKEUP;
      end
      ST_MAKEUP:  state_nxt = ST_WG;
      ST_WG:      state_nxt = ST_WET;
      ST_WET:     state_nxt = ST_MIX;
      ST_MIX:     state_nxt = ST_APPLY_L;
      ST_APPLY_L: state_nxt = ST_APPLY_R;
      ST_APPLY_R: state_nxt = ST_SAT_R;
      ST_SAT_R:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Shared multiplier operands and divider start
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    unique case (state_r)
      ST_ENV_A: begin
        mul_a = MUL_W'(c_r);
        mul_b = MUL_W'(env_r);
      end
      ST_ENV_B: begin
        mul_a = MUL_W'(one_minus_c);
        mul_b = MUL_W'(rect_r);
      end
      ST_THR: begin
        div_start = over;
      end
      ST_MAKEUP: begin
        mul_a = MUL_W'(gr_r);
        mul_b = MUL_W'(makeup_r);
      end
      ST_WET: begin
        mul_a = wg_r;
        mul_b = MUL_W'(wet_sat);
      end
      ST_APPLY_L: begin
        mul_a = MUL_W'(l_abs[EW-1:0]);
        mul_b = t_r;
      end
      ST_APPLY_R: begin
        mul_a = MUL_W'(r_abs[EW-1:0]);
        mul_b = t_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Envelope state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r <= '0;
    end else if (state_r == ST_ENV_UPD) begin
      env_r <= env_sum[EW+23:24];
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (in_accept) begin
      l_r    <= in_l_c;
      r_r    <= in_r_c;
      byp_r  <= (mode_r == MODE_BYPASS);
      rect_r <= in_sum_abs[EW:1];
    end
    unique case (state_r)
      ST_COEF:    c_r <= c_sel;
      ST_ENV_B:   acc_r <= prod_r;
      ST_THR: begin
        if (!over) gr_r <= ONE_Q24;
      end
      ST_DIV: begin
        if (div_done) gr_r <= div_quot;
      end
      ST_WG:      wg_r <= wg_sum[16 +: MUL_W];
      ST_MIX:     t_r <= mix_sum[16 +: MUL_W];
      ST_APPLY_R: lmag_r <= m_sat;
      ST_SAT_R:   rmag_r <= m_sat;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (byp_r) begin
        out_left_r  <= l_r[SAMPLE_W-1:0];
        out_right_r <= r_r[SAMPLE_W-1:0];
        out_clip_r  <= 1'b0;
        out_seg_r   <= '0;
      end else begin
        out_left_r  <= lo_s[SAMPLE_W-1:0];
        out_right_r <= ro_s[SAMPLE_W-1:0];
        out_clip_r  <= (lmag_r >= V_CLIP) || (rmag_r >= V_CLIP);
        out_seg_r   <= meter_count(gr_r);
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left_out       = out_left_r;
  assign out_right_out      = out_right_r;
  assign out_clip_flag      = out_clip_r;
  assign out_meter_segments = out_seg_r;

  spc_div #(
    .SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .den   (den_calc),
    .done  (div_done),
    .quot  (div_quot)
  );

  a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
    env_r <= VMAX_E)
    else $error("envelope above full scale");

  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider result outside its wait state");

  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result loaded outside the final state");

endmodule

`default_nettype wire
